// ----- hw/rtl/ela_pkg.sv -----
package ela_pkg;

    localparam int MAX_SLOTS_DEF = 512;
    localparam int ID_BITS_DEF   = 10;

    localparam int TS_W     = 64;
    localparam int CALLS_W  = 32;
    localparam int SLOT_O_W = 9;
    localparam int USED_O_W = 10;
    localparam int STAT_W   = 2;

    localparam int OUT_RAW_W = SLOT_O_W + TS_W + CALLS_W + TS_W + TS_W + USED_O_W;
    localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

    typedef enum logic [STAT_W-1:0] {
        ST_ENTRY  = 2'd0,
        ST_EXIT   = 2'd1,
        ST_ORPHAN = 2'd2,
        ST_DROP   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ALLOC,
        S_DIFF,
        S_ACC,
        S_OUT
    } t_state;

endpackage

// ----- hw/rtl/event_latency_accumulator_top.sv -----
// Sequence: on a hit in slot k the tag scan stops at slot k, then S_DIFF, S_ACC, S_OUT;
//   a new id scans every used slot, then S_ALLOC, S_DIFF, S_ACC, S_OUT; a drop goes to S_OUT.
// Throughput: one transaction at a time, set by the tag scan (one slot per cycle);
//   the next input transaction is accepted in the cycle after the result transaction at the earliest.
// Reset (i_rst_n, synchronous, active low) clears the sequencer, the slot fill
//   count and the completion total; slot memory is not cleared (no clearing pass).
module event_latency_accumulator_top #(
    parameter int MAX_SLOTS = ela_pkg::MAX_SLOTS_DEF,
    parameter int ID_BITS   = ela_pkg::ID_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // event_id [ID_BITS-1:0], timestamp [ID_BITS+63:ID_BITS], zero pad above
    input  logic [((ID_BITS + 64 + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // kind [0]
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // slot [8:0], duration [72:9], slot_calls [104:73], slot_time [168:105],
    // completions [232:169], used_entries [242:233], zero pad above
    output logic [ela_pkg::OUT_W-1:0]           m_axis_tdata,
    // status [1:0]
    output logic [ela_pkg::STAT_W-1:0]          m_axis_tuser
);
    import ela_pkg::*;

    localparam int SLOT_W = $clog2(MAX_SLOTS);
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);

    typedef struct packed {
        logic [ID_BITS-1:0] tag;
        logic [TS_W-1:0]    start;
        logic               busy;
        logic [CALLS_W-1:0] calls;
        logic [TS_W-1:0]    ttime;
    } t_entry;

    t_entry mem [MAX_SLOTS];
    t_entry r_rd;

    t_state r_state, n_state;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_cmp_v, n_cmp_v;
    logic [SLOT_W-1:0]  r_cmp_idx, n_cmp_idx;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    t_entry             r_ent, n_ent;
    logic               r_kind, n_kind;
    logic [ID_BITS-1:0] r_tag, n_tag;
    logic [TS_W-1:0]    r_ts, n_ts;
    logic [TS_W-1:0]    r_dur, n_dur;
    t_status            r_status, n_status;
    logic [CNT_W-1:0]   r_used, n_used;
    logic [TS_W-1:0]    r_done, n_done;
    logic [SLOT_W-1:0]  r_o_slot, n_o_slot;
    logic [TS_W-1:0]    r_o_dur, n_o_dur;
    logic [CALLS_W-1:0] r_o_calls, n_o_calls;
    logic [TS_W-1:0]    r_o_time, n_o_time;

    logic              wr_en;
    t_entry            wr_data;
    logic [SLOT_W-1:0] rd_addr;
    logic              issuing;
    logic              hit;
    logic [TS_W:0]     diff;
    logic [TS_W:0]     tsum;
    t_entry            upd;

    assign issuing = r_idx < r_used;
    assign hit     = r_cmp_v && (r_rd.tag == r_tag);
    assign diff    = {1'b0, r_ts} - {1'b0, r_ent.start};
    assign tsum    = {1'b0, r_ent.ttime} + {1'b0, r_dur};
    assign rd_addr = r_idx[SLOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_slot] <= wr_data;
        end
        r_rd <= mem[rd_addr];
    end

    always_comb begin
        upd = r_ent;
        case (r_status)
            ST_ENTRY: begin
                upd.start = r_ts;
                upd.busy  = 1'b1;
            end
            ST_EXIT: begin
                upd.busy  = 1'b0;
                upd.calls = (&r_ent.calls) ? r_ent.calls : r_ent.calls + 1'b1;
                upd.ttime = tsum[TS_W] ? {TS_W{1'b1}} : tsum[TS_W-1:0];
            end
            default: ;
        endcase
    end

    // next state and datapath
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_cmp_v   = r_cmp_v;
        n_cmp_idx = r_cmp_idx;
        n_slot    = r_slot;
        n_ent     = r_ent;
        n_kind    = r_kind;
        n_tag     = r_tag;
        n_ts      = r_ts;
        n_dur     = r_dur;
        n_status  = r_status;
        n_used    = r_used;
        n_done    = r_done;
        n_o_slot  = r_o_slot;
        n_o_dur   = r_o_dur;
        n_o_calls = r_o_calls;
        n_o_time  = r_o_time;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_kind  = s_axis_tuser;
                    n_tag   = s_axis_tdata[ID_BITS-1:0];
                    n_ts    = s_axis_tdata[ID_BITS+TS_W-1:ID_BITS];
                    n_idx   = '0;
                    n_cmp_v = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_cmp_v   = issuing;
                n_cmp_idx = rd_addr;
                if (issuing) begin
                    n_idx = r_idx + 1'b1;
                end
                if (hit) begin
                    n_slot  = r_cmp_idx;
                    n_ent   = r_rd;
                    n_state = S_DIFF;
                end else if (!issuing) begin
                    if (r_used >= CNT_W'(MAX_SLOTS)) begin
                        n_status  = ST_DROP;
                        n_o_slot  = '0;
                        n_o_dur   = '0;
                        n_o_calls = '0;
                        n_o_time  = '0;
                        n_state   = S_OUT;
                    end else begin
                        n_state = S_ALLOC;
                    end
                end
            end
            S_ALLOC: begin
                n_slot    = r_used[SLOT_W-1:0];
                n_ent     = '0;
                n_ent.tag = r_tag;
                n_used    = r_used + 1'b1;
                n_state   = S_DIFF;
            end
            S_DIFF: begin
                n_dur = '0;
                if (!r_kind) begin
                    n_status = ST_ENTRY;
                end else if (r_ent.busy) begin
                    n_status = ST_EXIT;
                    n_dur    = diff[TS_W] ? '0 : diff[TS_W-1:0];
                end else begin
                    n_status = ST_ORPHAN;
                end
                n_state = S_ACC;
            end
            S_ACC: begin
                if (r_status == ST_EXIT && !(&r_done)) begin
                    n_done = r_done + 1'b1;
                end
                n_o_slot  = r_slot;
                n_o_dur   = r_dur;
                n_o_calls = upd.calls;
                n_o_time  = upd.ttime;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        wr_en         = 1'b0;
        wr_data       = upd;
        case (r_state)
            S_IDLE:  s_axis_tready = 1'b1;
            S_ACC:   wr_en = 1'b1;
            S_OUT:   m_axis_tvalid = 1'b1;
            default: ;
        endcase
    end

    assign m_axis_tuser = r_status;
    assign m_axis_tdata = {
        (OUT_W - OUT_RAW_W)'(0),
        USED_O_W'(r_used),
        r_done,
        r_o_time,
        r_o_calls,
        r_o_dur,
        SLOT_O_W'(r_o_slot)
    };

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_done  <= '0;
            r_cmp_v <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_done  <= n_done;
            r_cmp_v <= n_cmp_v;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= n_cmp_idx;
        r_slot    <= n_slot;
        r_ent     <= n_ent;
        r_kind    <= n_kind;
        r_tag     <= n_tag;
        r_ts      <= n_ts;
        r_dur     <= n_dur;
        r_status  <= n_status;
        r_o_slot  <= n_o_slot;
        r_o_dur   <= n_o_dur;
        r_o_calls <= n_o_calls;
        r_o_time  <= n_o_time;
    end

endmodule
